FILE: src/gdsfcr_pkg.sv
// Package for the GDSF replacement core: field widths, request and result
// structs, function and status codes, sequencer states. No dependencies.
package gdsfcr_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam int KEY_W  = 32;
    localparam int SIZE_W = 24;
    localparam int FREQ_W = 32;
    localparam int K_W    = 48;   // 32.16 fixed point
    localparam int CAP_W  = 31;
    localparam int COST_W = 16;

    localparam logic [K_W-1:0]    K_SAT   = '1;
    localparam logic [FREQ_W-1:0] F_SAT   = '1;
    localparam logic [CAP_W-1:0]  CAP_RST = 31'd1048576;
    localparam logic [COST_W-1:0] COST_RST = 16'd1;
    localparam logic [CAP_W-1:0]  LIM_RST = 31'h7FFF_FFFF;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_CAP  = 2'd0;
    localparam logic [1:0] REG_COST = 2'd1;
    localparam logic [1:0] REG_LIM  = 2'd2;

    localparam logic KIND_EVICT = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_REFER  = 2'd1,
        FN_REMOVE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_REFERRED  = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_TOO_LARGE = 3'd5,
        ST_FULL      = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]        func;
        logic [KEY_W-1:0]  object_key;
        logic [SIZE_W-1:0] object_size;
    } t_req;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  result_key;
        logic [2:0]        status;
        logic [CAP_W-1:0]  free_bytes;
        logic              last;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_DISP,
        S_EV_RH, S_EV_RE, S_EV_TAKE, S_EV_CHK,
        S_RM_RH, S_RM_RE, S_RM_LD,
        S_NEW, S_PR_MUL, S_PR_DIV, S_PR_ADD,
        S_ADD_GO, S_REF_TEST, S_HALVE,
        S_SU_CHK, S_SU_RDH, S_SU_RDE,
        S_SD_CHK, S_SD_B, S_SD_C, S_SD_D, S_SD_DEC,
        S_PLACE
    } t_state;

    typedef enum logic [1:0] {
        RET_EVICT, RET_ADD, RET_REMOVE, RET_REFER
    } t_ret;

endpackage

FILE: src/gdsfcr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gdsfcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/gdsf_cache_replacement_core.sv
// GDSF cache replacement core: key table, min-heap and sequencer.
// Depends on gdsfcr_pkg and gdsfcr_ram.
//
// Usage
//   Request channel: drive i_item and raise start; the transfer happens at a
//   rising edge with start high and busy low. busy stays high while the
//   request is worked on and falls in the cycle its final result is shown.
//   Result channel: each result is on o_result for one cycle with
//   o_result_valid high. An add that has to make room first gives one
//   eviction notice per evicted object, then the final status (last = 1).
//   The receiver cannot stall; results are never held back or repeated.
//   Configuration: APB-style, pready always high, registers at 0x0
//   (capacity), 0x4 (miss cost), 0x8 (halving limit). Write only while idle.
// Sequencing
//   Every request starts with a key scan of the entry RAM.
//   Priority update: a multiply step, then a bit-serial divider, then an add.
//   Heap sift: parent read per level up; left, then right child per level down.
//   A refer that trips halving adds a sweep over the entry RAM.
//   Each eviction reads the root slot and entry, then sifts down from the root.
//   Each RAM has a single read port; one request at a time.
// Reset: no entry valid, heap empty, inflation zero, registers at defaults.
// No clearing pass is needed: slot validity lives in flip-flops.
module gdsf_cache_replacement_core
    import gdsfcr_pkg::*;
#(
    parameter int ENTRIES = gdsfcr_pkg::ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  gdsfcr_pkg::t_req   i_item,
    output logic               o_result_valid,
    output gdsfcr_pkg::t_rsp   o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int LW  = IW + 2;
    localparam int UW  = SIZE_W + IW;
    localparam int FW  = (UW > CAP_W) ? UW : CAP_W;
    localparam int FW1 = FW + 1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [FREQ_W-1:0] freq;
        logic [K_W-1:0]    infl;
        logic [K_W-1:0]    prio;
        logic [IW-1:0]     hpos;
    } t_ent;

    localparam int EW = $bits(t_ent);

    // free bytes = capacity minus used, floored at zero
    function automatic logic [CAP_W-1:0] free_of(input logic [CAP_W-1:0] cap,
                                                 input logic [UW-1:0] used);
        logic [FW:0] c;
        logic [FW:0] u;
        begin
            c = FW1'(cap);
            u = FW1'(used);
            free_of = (c > u) ? CAP_W'(c - u) : '0;
        end
    endfunction

    // ---------------- registers ----------------
    t_state              r_state, n_state;
    logic [CAP_W-1:0]    r_cap, n_cap;
    logic [COST_W-1:0]   r_cost, n_cost;
    logic [CAP_W-1:0]    r_lim, n_lim;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [UW-1:0]       r_used, n_used;
    logic [K_W-1:0]      r_ginfl, n_ginfl;
    logic                r_ov, n_ov;
    t_rsp                r_out, n_out;

    t_req                r_req, n_req;
    logic [CW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_prev, n_prev;
    logic                r_pv, n_pv;
    logic                r_found, n_found;
    logic                r_hf, n_hf;
    logic [IW-1:0]       r_free, n_free;
    t_ent                r_mv, n_mv;
    logic [IW-1:0]       r_mslot, n_mslot;
    logic [IW-1:0]       r_pos, n_pos;
    t_ret                r_ret, n_ret;
    logic                r_first, n_first;
    t_ent                r_crec, n_crec;
    logic [IW-1:0]       r_cs, n_cs;
    logic [IW-1:0]       r_rs, n_rs;
    logic [IW-1:0]       r_cpos, n_cpos;
    logic                r_hasr, n_hasr;
    logic [63:0]         r_num, n_num;
    logic [SIZE_W-1:0]   r_rem, n_rem;
    logic [5:0]          r_dcnt, n_dcnt;

    // ---------------- memories ----------------
    logic             e_we;
    logic [IW-1:0]    e_waddr, e_raddr;
    t_ent             e_wdata, e_rdata;
    logic [EW-1:0]    e_rdata_raw;
    logic             h_we;
    logic [IW-1:0]    h_waddr, h_raddr, h_wdata, h_rdata;

    gdsfcr_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata_raw)
    );
    assign e_rdata = t_ent'(e_rdata_raw);

    gdsfcr_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    // ---------------- datapath helpers ----------------
    logic [IW-1:0]     w_par;
    logic [LW-1:0]     w_lc, w_rc, w_cnt_x;
    logic [CAP_W-1:0]  w_free;
    logic              w_no_fit;
    logic [SIZE_W-1:0] w_div;
    logic [SIZE_W:0]   w_rsh;
    logic              w_ge;
    logic [47:0]       w_prod;
    logic [K_W-1:0]    w_q;
    logic [K_W:0]      w_sum;
    logic [K_W-1:0]    w_k;
    logic [K_W-1:0]    w_lim_k;
    logic              w_halve;
    logic              w_cfg_we;

    assign w_par    = (r_pos - 1'b1) >> 1;
    assign w_lc     = {1'b0, r_pos, 1'b1};
    assign w_rc     = w_lc + 1'b1;
    assign w_cnt_x  = LW'(r_cnt);
    assign w_free   = free_of(r_cap, r_used);
    assign w_no_fit = (CAP_W'(r_req.object_size) > w_free) && (r_cnt != '0);

    // restoring divider, one quotient bit per cycle; size 0 divides as 1
    assign w_div  = (r_mv.size == '0) ? SIZE_W'(1) : r_mv.size;
    assign w_rsh  = {r_rem, r_num[63]};
    assign w_ge   = w_rsh >= {1'b0, w_div};
    assign w_prod = r_mv.freq * r_cost;
    assign w_q    = (r_num[63:K_W] != '0) ? K_SAT : r_num[K_W-1:0];
    assign w_sum  = {1'b0, w_q} + {1'b0, r_mv.infl};
    assign w_k    = w_sum[K_W] ? K_SAT : w_sum[K_W-1:0];

    assign w_lim_k = {1'b0, r_lim, 16'b0};
    assign w_halve = (r_mv.freq > FREQ_W'(r_lim)) || (r_mv.prio > w_lim_k)
                   || (r_mv.infl > w_lim_k);

    assign w_cfg_we = psel && penable && pwrite;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_cap   = r_cap;
        n_cost  = r_cost;
        n_lim   = r_lim;
        n_valid = r_valid;
        n_cnt   = r_cnt;
        n_used  = r_used;
        n_ginfl = r_ginfl;
        n_ov    = 1'b0;
        n_out   = r_out;
        n_req   = r_req;
        n_idx   = r_idx;
        n_prev  = r_prev;
        n_pv    = r_pv;
        n_found = r_found;
        n_hf    = r_hf;
        n_free  = r_free;
        n_mv    = r_mv;
        n_mslot = r_mslot;
        n_pos   = r_pos;
        n_ret   = r_ret;
        n_first = r_first;
        n_crec  = r_crec;
        n_cs    = r_cs;
        n_rs    = r_rs;
        n_cpos  = r_cpos;
        n_hasr  = r_hasr;
        n_num   = r_num;
        n_rem   = r_rem;
        n_dcnt  = r_dcnt;

        e_we    = 1'b0;
        e_waddr = r_mslot;
        e_wdata = r_mv;
        e_raddr = r_idx[IW-1:0];
        h_we    = 1'b0;
        h_waddr = r_pos;
        h_wdata = r_mslot;
        h_raddr = '0;

        if (w_cfg_we) begin
            case (paddr[3:2])
                REG_CAP:  n_cap  = pwdata[CAP_W-1:0];
                REG_COST: n_cost = pwdata[COST_W-1:0];
                REG_LIM:  n_lim  = pwdata[CAP_W-1:0];
                default:  ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_item;
                    n_idx   = '0;
                    n_pv    = 1'b0;
                    n_found = 1'b0;
                    n_hf    = 1'b0;
                    n_state = S_SCAN;
                end
            end

            // key search and lowest free slot, one entry per cycle
            S_SCAN: begin
                if (r_pv) begin
                    if (r_valid[r_prev] && e_rdata.key == r_req.object_key && !r_found) begin
                        n_found = 1'b1;
                        n_mslot = r_prev;
                        n_mv    = e_rdata;
                    end
                    if (!r_valid[r_prev] && !r_hf) begin
                        n_hf   = 1'b1;
                        n_free = r_prev;
                    end
                end
                n_prev = r_idx[IW-1:0];
                n_pv   = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == CW'(ENTRIES)) begin
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                n_out.kind       = KIND_FINAL;
                n_out.result_key = r_req.object_key;
                n_out.last       = 1'b1;
                n_out.status     = ST_NOT_FOUND;
                case (r_req.func)
                    FN_ADD: begin
                        if (r_found) begin
                            n_out.status = ST_PRESENT;
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end else if (CAP_W'(r_req.object_size) > r_cap) begin
                            n_out.status = ST_TOO_LARGE;
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_cnt == CW'(ENTRIES)) begin
                            n_out.status = ST_FULL;
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end else if (w_no_fit) begin
                            n_first = 1'b1;
                            n_state = S_EV_RH;
                        end else begin
                            n_state = S_NEW;
                        end
                    end
                    FN_REFER: begin
                        if (r_found) begin
                            if (r_mv.freq != F_SAT) begin
                                n_mv.freq = r_mv.freq + 1'b1;
                            end
                            n_state = S_PR_MUL;
                        end else begin
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    FN_REMOVE: begin
                        if (r_found) begin
                            n_valid[r_mslot] = 1'b0;
                            n_used = r_used - UW'(r_mv.size);
                            n_cnt  = r_cnt - 1'b1;
                            if (CW'(r_mv.hpos) < r_cnt - 1'b1) begin
                                n_pos   = r_mv.hpos;
                                n_ret   = RET_REMOVE;
                                n_state = S_RM_RH;
                            end else begin
                                n_out.status = ST_REMOVED;
                                n_ov    = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_ov    = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end

            // eviction: fetch root slot, then its entry
            S_EV_RH: begin
                h_raddr = '0;
                n_state = S_EV_RE;
            end
            S_EV_RE: begin
                n_cs    = h_rdata;
                e_raddr = h_rdata;
                n_state = S_EV_TAKE;
            end
            S_EV_TAKE: begin
                if (r_first) begin
                    n_ginfl = e_rdata.prio;
                    n_first = 1'b0;
                end
                n_valid[r_cs]    = 1'b0;
                n_used           = r_used - UW'(e_rdata.size);
                n_ov             = 1'b1;
                n_out.kind       = KIND_EVICT;
                n_out.result_key = e_rdata.key;
                n_out.status     = ST_ADDED;
                n_out.last       = 1'b0;
                if (r_cs < r_free) begin
                    n_free = r_cs;
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt != CW'(1)) begin
                    n_pos   = '0;
                    n_ret   = RET_EVICT;
                    n_state = S_RM_RH;
                end else begin
                    n_state = S_EV_CHK;
                end
            end
            S_EV_CHK: begin
                n_state = w_no_fit ? S_EV_RH : S_NEW;
            end

            // removal at r_pos: last heap element becomes the mover
            S_RM_RH: begin
                h_raddr = r_cnt[IW-1:0];
                n_state = S_RM_RE;
            end
            S_RM_RE: begin
                n_mslot = h_rdata;
                e_raddr = h_rdata;
                n_state = S_RM_LD;
            end
            S_RM_LD: begin
                n_mv    = e_rdata;
                n_state = S_SU_CHK;
            end

            S_NEW: begin
                n_mv.key  = r_req.object_key;
                n_mv.size = r_req.object_size;
                n_mv.freq = FREQ_W'(1);
                n_mv.infl = r_ginfl;
                n_mv.prio = '0;
                n_mv.hpos = '0;
                n_mslot   = r_free;
                n_state   = S_PR_MUL;
            end

            // K = (f*cost << 16) / size + l, both steps saturating
            S_PR_MUL: begin
                n_num   = {w_prod, 16'b0};
                n_rem   = '0;
                n_dcnt  = '0;
                n_state = S_PR_DIV;
            end
            S_PR_DIV: begin
                n_rem  = w_ge ? SIZE_W'(w_rsh - {1'b0, w_div}) : w_rsh[SIZE_W-1:0];
                n_num  = {r_num[62:0], w_ge};
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == '1) begin
                    n_state = S_PR_ADD;
                end
            end
            S_PR_ADD: begin
                n_mv.prio = w_k;
                n_state   = (r_req.func == FN_ADD) ? S_ADD_GO : S_REF_TEST;
            end

            S_ADD_GO: begin
                n_valid[r_mslot] = 1'b1;
                n_used  = r_used + UW'(r_mv.size);
                n_pos   = r_cnt[IW-1:0];
                n_cnt   = r_cnt + 1'b1;
                n_ret   = RET_ADD;
                n_state = S_SU_CHK;
            end

            S_REF_TEST: begin
                n_pos = r_mv.hpos;
                n_ret = RET_REFER;
                if (w_halve) begin
                    e_we      = 1'b1;
                    n_mv.freq = r_mv.freq >> 1;
                    n_mv.infl = r_mv.infl >> 1;
                    n_ginfl   = r_ginfl >> 1;
                    n_idx     = '0;
                    n_pv      = 1'b0;
                    n_state   = S_HALVE;
                end else begin
                    n_state = S_SU_CHK;
                end
            end

            // halving sweep: read entry i, write back entry i-1
            S_HALVE: begin
                if (r_pv && r_valid[r_prev]) begin
                    e_we         = 1'b1;
                    e_waddr      = r_prev;
                    e_wdata      = e_rdata;
                    e_wdata.freq = e_rdata.freq >> 1;
                    e_wdata.infl = e_rdata.infl >> 1;
                end
                n_prev = r_idx[IW-1:0];
                n_pv   = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == CW'(ENTRIES)) begin
                    n_state = S_SU_CHK;
                end
            end

            // sift up with a hole; mover stays in r_mv until placed
            S_SU_CHK: begin
                h_raddr = w_par;
                n_state = (r_pos == '0) ? S_SD_CHK : S_SU_RDH;
            end
            S_SU_RDH: begin
                n_cs    = h_rdata;
                e_raddr = h_rdata;
                n_state = S_SU_RDE;
            end
            S_SU_RDE: begin
                if (r_mv.prio < e_rdata.prio) begin
                    h_we         = 1'b1;
                    h_wdata      = r_cs;
                    e_we         = 1'b1;
                    e_waddr      = r_cs;
                    e_wdata      = e_rdata;
                    e_wdata.hpos = r_pos;
                    n_pos        = w_par;
                    n_state      = S_SU_CHK;
                end else begin
                    n_state = S_SD_CHK;
                end
            end

            // sift down: left child, then right child if present
            S_SD_CHK: begin
                h_raddr = w_lc[IW-1:0];
                n_cpos  = w_lc[IW-1:0];
                n_hasr  = w_rc < w_cnt_x;
                n_state = (w_lc >= w_cnt_x) ? S_PLACE : S_SD_B;
            end
            S_SD_B: begin
                n_cs    = h_rdata;
                e_raddr = h_rdata;
                h_raddr = r_cpos + 1'b1;
                n_state = S_SD_C;
            end
            S_SD_C: begin
                n_crec  = e_rdata;
                n_rs    = h_rdata;
                e_raddr = h_rdata;
                n_state = r_hasr ? S_SD_D : S_SD_DEC;
            end
            S_SD_D: begin
                if (e_rdata.prio < r_crec.prio) begin
                    n_crec = e_rdata;
                    n_cs   = r_rs;
                    n_cpos = r_cpos + 1'b1;
                end
                n_state = S_SD_DEC;
            end
            S_SD_DEC: begin
                if (r_crec.prio < r_mv.prio) begin
                    h_we         = 1'b1;
                    h_wdata      = r_cs;
                    e_we         = 1'b1;
                    e_waddr      = r_cs;
                    e_wdata      = r_crec;
                    e_wdata.hpos = r_pos;
                    n_pos        = r_cpos;
                    n_state      = S_SD_CHK;
                end else begin
                    n_state = S_PLACE;
                end
            end

            S_PLACE: begin
                h_we         = 1'b1;
                h_wdata      = r_mslot;
                e_we         = 1'b1;
                e_wdata      = r_mv;
                e_wdata.hpos = r_pos;
                n_out.kind       = KIND_FINAL;
                n_out.result_key = r_req.object_key;
                n_out.last       = 1'b1;
                n_state          = S_IDLE;
                case (r_ret)
                    RET_EVICT:  n_state = S_EV_CHK;
                    RET_ADD: begin
                        n_out.status = ST_ADDED;
                        n_ov         = 1'b1;
                    end
                    RET_REMOVE: begin
                        n_out.status = ST_REMOVED;
                        n_ov         = 1'b1;
                    end
                    default: begin
                        n_out.status = ST_REFERRED;
                        n_ov         = 1'b1;
                    end
                endcase
            end

            default: n_state = S_IDLE;
        endcase

        // every result reports the budget as it stands after that result
        n_out.free_bytes = free_of(n_cap, n_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CAP_RST;
            r_cost  <= COST_RST;
            r_lim   <= LIM_RST;
            r_valid <= '0;
            r_cnt   <= '0;
            r_used  <= '0;
            r_ginfl <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap   <= n_cap;
            r_cost  <= n_cost;
            r_lim   <= n_lim;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            r_used  <= n_used;
            r_ginfl <= n_ginfl;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_prev  <= n_prev;
        r_pv    <= n_pv;
        r_found <= n_found;
        r_hf    <= n_hf;
        r_free  <= n_free;
        r_mv    <= n_mv;
        r_mslot <= n_mslot;
        r_pos   <= n_pos;
        r_ret   <= n_ret;
        r_first <= n_first;
        r_crec  <= n_crec;
        r_cs    <= n_cs;
        r_rs    <= n_rs;
        r_cpos  <= n_cpos;
        r_hasr  <= n_hasr;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
    end

    // ---------------- ports ----------------
    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_ov;
    assign o_result       = r_out;
    assign pready         = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_CAP:  prdata = {1'b0, r_cap};
            REG_COST: prdata = {16'b0, r_cost};
            REG_LIM:  prdata = {1'b0, r_lim};
            default:  prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(ENTRIES))
        else $error("heap count above table size");

    a_cnt_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> $countones(r_valid) == int'(r_cnt))
        else $error("heap count disagrees with valid slots");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.last |-> r_state == S_IDLE)
        else $error("final result shown while still busy");

    a_notice_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.kind == KIND_EVICT |-> busy && !r_out.last)
        else $error("eviction notice outside an add");

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> r_state == S_SCAN)
        else $error("accepted request did not start the key scan");
`endif

endmodule
